// File: hw/rtl/fmch_pkg.sv
// ----------------------------------------------------------------------------
// fmch_pkg
// Shared widths, beat structs and the hit resolve function for the
// first-match circle hit test chain.
// ----------------------------------------------------------------------------
package fmch_pkg;

  // table size and angle format
  localparam int MAX_SPOTS  = 16;
  localparam int ANGLE_BITS = 16;
  localparam int RAD_W      = ANGLE_BITS - 1;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;

  // signed difference of two angles, its square and the radius square
  localparam int DIFF_W = ANGLE_BITS + 1;
  localparam int SQ_W   = 2 * ANGLE_BITS;
  localparam int R2_W   = 2 * RAD_W;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // table write broadcast to every cell
  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      idx;
    logic [ANGLE_BITS-1:0] alt;
    logic [ANGLE_BITS-1:0] az;
    logic [RAD_W-1:0]      rad;
  } wr_t;

  // query beat handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic [ANGLE_BITS-1:0] qalt;
    logic [ANGLE_BITS-1:0] qaz;
    logic [CNT_W-1:0]      cnt;
    logic                  found;
    logic [IDX_W-1:0]      fidx;
    logic                  pend;
    logic [IDX_W-1:0]      pidx;
    logic [SQ_W-1:0]       sq_alt;
    logic [SQ_W-1:0]       sq_az;
    logic [R2_W-1:0]       r2;
  } tok_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } res_t;

  // finish the compare left pending by the previous cell
  function automatic res_t fmch_resolve(input tok_t t);
    logic [SQ_W:0] d2;
    logic          inside_c;
    res_t          r;
    d2       = {1'b0, t.sq_alt} + {1'b0, t.sq_az};
    inside_c = t.pend && (d2 < (SQ_W + 1)'(t.r2));
    r.hit    = t.found || inside_c;
    r.idx    = t.found ? t.fidx : t.pidx;
    return r;
  endfunction

endpackage

// File: hw/rtl/fmch_cell.sv
// ----------------------------------------------------------------------------
// fmch_cell
// One table entry of the chain. Holds centre and squared radius, settles
// the previous cell's compare and squares its own distance terms.
// ----------------------------------------------------------------------------
module fmch_cell import fmch_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  wr_t              wr,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [ANGLE_BITS-1:0] alt_r;
  logic [ANGLE_BITS-1:0] az_r;
  logic [R2_W-1:0]       r2_r;
  tok_t                  tok_r;
  tok_t                  tok_nxt;

  logic signed [DIFF_W-1:0]   d_alt;
  logic signed [DIFF_W-1:0]   d_az;
  logic signed [2*DIFF_W-1:0] p_alt;
  logic signed [2*DIFF_W-1:0] p_az;
  res_t                       res;

  // entry storage, radius squared on the way in
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      alt_r <= wr.alt;
      az_r  <= wr.az;
      r2_r  <= R2_W'(wr.rad) * R2_W'(wr.rad);
    end
  end

  // own distance terms
  always_comb begin
    d_alt = $signed({tok_in.qalt[ANGLE_BITS-1], tok_in.qalt})
          - $signed({alt_r[ANGLE_BITS-1], alt_r});
    d_az  = $signed({tok_in.qaz[ANGLE_BITS-1], tok_in.qaz})
          - $signed({az_r[ANGLE_BITS-1], az_r});
    p_alt = d_alt * d_alt;
    p_az  = d_az * d_az;
  end

  // next beat: settle previous compare, queue this one
  always_comb begin
    res            = fmch_resolve(tok_in);
    tok_nxt        = tok_in;
    tok_nxt.found  = res.hit;
    tok_nxt.fidx   = res.idx;
    tok_nxt.pend   = tok_in.valid && !res.hit
                   && ({1'b0, cell_idx} < tok_in.cnt);
    tok_nxt.pidx   = cell_idx;
    tok_nxt.sq_alt = p_alt[SQ_W-1:0];
    tok_nxt.sq_az  = p_az[SQ_W-1:0];
    tok_nxt.r2     = r2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: hw/rtl/first_match_circle_hit_test_core.sv
// ----------------------------------------------------------------------------
// first_match_circle_hit_test_core
// Circle hit test over a table of hot regions, first match in index order.
// ----------------------------------------------------------------------------
// A table write (in_command low) is taken and busy stays low, so while no
// query is in flight writes can follow each other in every cycle. A query
// raises busy while it walks the row of 16 entry cells one cell per clock,
// then a final register settles the last compare, and the result appears
// on out_hit / out_hit_index with out_valid high for exactly one cycle.
// The receiver cannot stall; the next beat may start in the cycle out_valid
// is high, and no new beat is taken while a query is still in the row.
// cfg_wdata sets the number of entries searched (saturated at 16); it is to
// be written by the user only while the block is idle, and the block itself
// does not enforce this.
module first_match_circle_hit_test_core import fmch_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [ANGLE_BITS-1:0] in_centre_alt,
  input  logic [ANGLE_BITS-1:0] in_centre_az,
  input  logic [RAD_W-1:0]      in_radius,
  input  logic [ANGLE_BITS-1:0] in_query_alt,
  input  logic [ANGLE_BITS-1:0] in_query_az,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [IDX_W-1:0]      out_hit_index
);

  logic             busy_r;
  logic [CNT_W-1:0] spot_count_r;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [IDX_W-1:0] out_hit_index_r;

  logic             accept;
  logic [CNT_W-1:0] cnt_sat;
  wr_t              wr;
  tok_t             tok [0:MAX_SPOTS];
  res_t             res;

  assign accept  = start && !busy_r;
  assign cnt_sat = (spot_count_r > CNT_W'(MAX_SPOTS)) ? CNT_W'(MAX_SPOTS) : spot_count_r;

  // table write beat
  always_comb begin
    wr.en  = accept && (in_command == CMD_WRITE);
    wr.idx = in_entry_index;
    wr.alt = in_centre_alt;
    wr.az  = in_centre_az;
    wr.rad = in_radius;
  end

  // query beat entering the chain
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = accept && (in_command == CMD_QUERY);
    tok[0].qalt  = in_query_alt;
    tok[0].qaz   = in_query_az;
    tok[0].cnt   = cnt_sat;
  end

  // row of entry cells
  for (genvar g = 0; g < MAX_SPOTS; g++) begin : g_cell
    fmch_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .wr       (wr),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  assign res = fmch_resolve(tok[MAX_SPOTS]);

  // control, config and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      spot_count_r    <= '0;
      out_valid_r     <= 1'b0;
      out_hit_r       <= 1'b0;
      out_hit_index_r <= '0;
    end else begin
      if (cfg_we) begin
        spot_count_r <= cfg_wdata;
      end
      if (accept && (in_command == CMD_QUERY)) begin
        busy_r <= 1'b1;
      end else if (tok[MAX_SPOTS].valid) begin
        busy_r <= 1'b0;
      end
      out_valid_r     <= tok[MAX_SPOTS].valid;
      out_hit_r       <= res.hit;
      out_hit_index_r <= res.hit ? res.idx : '0;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_index = out_hit_index_r;

endmodule

// File: hw/rtl/fmch_checker.sv
// ----------------------------------------------------------------------------
// fmch_checker
// Port-level checks of the hit test core: query latency, busy window and
// result shape.
// ----------------------------------------------------------------------------
module fmch_checker import fmch_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             in_command,
  input logic             out_valid,
  input logic             out_hit,
  input logic [IDX_W-1:0] out_hit_index
);

  // query beat raises busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_QUERY) |=> busy)
    else $error("busy not raised after query beat");

  // result strobe follows the query beat through the cell row and the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_QUERY) |-> ##17 out_valid)
    else $error("query result missing at expected cycle");

  // busy already dropped when the result shows
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy still high with result");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_hit_index == '0))
    else $error("nonzero index on miss");

  // one strobe per query
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind first_match_circle_hit_test_core fmch_checker u_fmch_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_command    (in_command),
  .out_valid     (out_valid),
  .out_hit       (out_hit),
  .out_hit_index (out_hit_index)
);

// File: test/first_match_circle_hit_test_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_match_circle_hit_test_core_tb
// Drives table writes and hit queries into the circle hit test core. A
// scoreboard keeps its own copy of the spot table and the active count,
// works out the first containing entry for every accepted query and checks
// each strobed result against it. Directed beats cover the field extremes,
// the boundary and the zero count; random phases run over several counts.
// ----------------------------------------------------------------------------
module first_match_circle_hit_test_core_tb;
  import fmch_pkg::*;

  localparam int CLK_HALF_NS  = 4;
  localparam int RST_CYCLES   = 5;
  localparam int SETTLE_CYCLES = 24;
  localparam int WDOG_LIMIT   = 2000;
  localparam int PHASE_BEATS  = 128;
  localparam int NUM_PHASES   = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_command;
  logic [IDX_W-1:0]      in_entry_index;
  logic [ANGLE_BITS-1:0] in_centre_alt;
  logic [ANGLE_BITS-1:0] in_centre_az;
  logic [RAD_W-1:0]      in_radius;
  logic [ANGLE_BITS-1:0] in_query_alt;
  logic [ANGLE_BITS-1:0] in_query_az;
  logic                  cfg_we;
  logic [CNT_W-1:0]      cfg_wdata;
  logic                  out_valid;
  logic                  out_hit;
  logic [IDX_W-1:0]      out_hit_index;

  // one input beat as driven on the ports
  typedef struct packed {
    logic                  cmd;
    logic [IDX_W-1:0]      idx;
    logic [ANGLE_BITS-1:0] calt;
    logic [ANGLE_BITS-1:0] caz;
    logic [RAD_W-1:0]      rad;
    logic [ANGLE_BITS-1:0] qalt;
    logic [ANGLE_BITS-1:0] qaz;
  } region_beat_t;

  // spot table mirror and expected hit results
  class hit_scoreboard;
    logic [ANGLE_BITS-1:0] tab_alt [MAX_SPOTS];
    logic [ANGLE_BITS-1:0] tab_az  [MAX_SPOTS];
    logic [RAD_W-1:0]      tab_rad [MAX_SPOTS];
    logic [CNT_W-1:0]      active_count;
    res_t                  pending_hits [$];
    int                    errors;

    function new();
      for (int i = 0; i < MAX_SPOTS; i++) begin
        tab_alt[i] = '0;
        tab_az[i]  = '0;
        tab_rad[i] = '0;
      end
      active_count = '0;
      errors       = 0;
    endfunction

    // scan entries in index order, strict inside test
    function res_t first_hit(logic [ANGLE_BITS-1:0] qalt, logic [ANGLE_BITS-1:0] qaz);
      res_t   r;
      int     n;
      longint da, dz, d2, r2;
      r.hit = 1'b0;
      r.idx = '0;
      n = (active_count > CNT_W'(MAX_SPOTS)) ? MAX_SPOTS : int'(active_count);
      for (int i = 0; i < n; i++) begin
        da = longint'($signed(tab_alt[i])) - longint'($signed(qalt));
        dz = longint'($signed(tab_az[i])) - longint'($signed(qaz));
        d2 = da * da + dz * dz;
        r2 = longint'(tab_rad[i]) * longint'(tab_rad[i]);
        if (d2 < r2) begin
          r.hit = 1'b1;
          r.idx = IDX_W'(i);
          return r;
        end
      end
      return r;
    endfunction

    // accepted input beat: update the table or queue a result
    function void note_beat(region_beat_t b);
      if (b.cmd == CMD_WRITE) begin
        tab_alt[b.idx] = b.calt;
        tab_az[b.idx]  = b.caz;
        tab_rad[b.idx] = b.rad;
      end else begin
        pending_hits = {pending_hits, first_hit(b.qalt, b.qaz)};
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic hit, logic [IDX_W-1:0] idx);
      res_t exp_r;
      if (pending_hits.size() == 0) begin
        report($sformatf("unexpected result hit=%0b idx=%0d", hit, idx));
      end else begin
        exp_r = pending_hits.pop_front();
        if (hit !== exp_r.hit)
          report($sformatf("hit %0b, expected %0b", hit, exp_r.hit));
        if (idx !== exp_r.idx)
          report($sformatf("hit_index %0d, expected %0d", idx, exp_r.idx));
      end
    endtask
  endclass

  hit_scoreboard sb;
  bit            idle_on;
  int            quiet_cycles;

  first_match_circle_hit_test_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_centre_alt  (in_centre_alt),
    .in_centre_az   (in_centre_az),
    .in_radius      (in_radius),
    .in_query_alt   (in_query_alt),
    .in_query_az    (in_query_az),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_hit_index  (out_hit_index)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_hit, out_hit_index);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic region_beat_t mk_write(logic [IDX_W-1:0] idx,
                                            logic [ANGLE_BITS-1:0] alt,
                                            logic [ANGLE_BITS-1:0] az,
                                            logic [RAD_W-1:0] rad);
    region_beat_t b;
    b.cmd  = CMD_WRITE;
    b.idx  = idx;
    b.calt = alt;
    b.caz  = az;
    b.rad  = rad;
    b.qalt = ANGLE_BITS'($urandom());
    b.qaz  = ANGLE_BITS'($urandom());
    return b;
  endfunction

  function automatic region_beat_t mk_query(logic [ANGLE_BITS-1:0] qalt,
                                            logic [ANGLE_BITS-1:0] qaz);
    region_beat_t b;
    b.cmd  = CMD_QUERY;
    b.idx  = IDX_W'($urandom());
    b.calt = ANGLE_BITS'($urandom());
    b.caz  = ANGLE_BITS'($urandom());
    b.rad  = RAD_W'($urandom());
    b.qalt = qalt;
    b.qaz  = qaz;
    return b;
  endfunction

  // drive one beat from a falling edge, hold start until accepted
  task automatic send_beat(region_beat_t b);
    if (idle_on) begin
      if ($urandom_range(0, 7) == 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
      while ($urandom_range(0, 99) < 33) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    in_command     = b.cmd;
    in_entry_index = b.idx;
    in_centre_alt  = b.calt;
    in_centre_az   = b.caz;
    in_radius      = b.rad;
    in_query_alt   = b.qalt;
    in_query_az    = b.qaz;
    start          = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(b);
    @(negedge clk);
  endtask

  // wait for all results, let the block settle
  task automatic drain();
    start = 1'b0;
    while (sb.pending_hits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_spot_count(logic [CNT_W-1:0] value);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    sb.active_count = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = CNT_W'($urandom());
  endtask

  // random beat: writes with mixed radii, queries mostly near an entry
  task automatic send_random_beat();
    region_beat_t b;
    int k, r, oa, oz, ca, cz, pick;
    k = $urandom_range(0, MAX_SPOTS - 1);
    r = int'(sb.tab_rad[k]);
    ca = int'($signed(sb.tab_alt[k]));
    cz = int'($signed(sb.tab_az[k]));
    if ($urandom_range(0, 99) < 35) begin
      b = mk_write(IDX_W'($urandom()), ANGLE_BITS'($urandom()), ANGLE_BITS'($urandom()),
                   RAD_W'($urandom()));
      pick = $urandom_range(0, 2);
      if (pick == 0) b.rad = RAD_W'($urandom_range(0, 200));
      else if (pick == 1) b.rad = RAD_W'($urandom_range(0, 4000));
      // overlapping regions exercise the first-match order
      if ($urandom_range(0, 9) < 3) begin
        b.calt = ANGLE_BITS'(ca + $urandom_range(0, 400) - 200);
        b.caz  = ANGLE_BITS'(cz + $urandom_range(0, 400) - 200);
      end
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        oa = int'($urandom_range(0, 2 * (r + 2))) - (r + 2);
        oz = int'($urandom_range(0, 2 * (r + 2))) - (r + 2);
        b = mk_query(ANGLE_BITS'(ca + oa), ANGLE_BITS'(cz + oz));
      end else if (pick < 7) begin
        // exactly on the rim
        if ($urandom_range(0, 1) == 0) b = mk_query(ANGLE_BITS'(ca + r), ANGLE_BITS'(cz));
        else b = mk_query(ANGLE_BITS'(ca), ANGLE_BITS'(cz - r));
      end else begin
        b = mk_query(ANGLE_BITS'($urandom()), ANGLE_BITS'($urandom()));
      end
    end
    send_beat(b);
  endtask

  // main sequence
  initial begin
    logic [CNT_W-1:0] phase_count [NUM_PHASES];
    sb             = new();
    idle_on        = 1'b1;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = CMD_WRITE;
    in_entry_index = '0;
    in_centre_alt  = '0;
    in_centre_az   = '0;
    in_radius      = '0;
    in_query_alt   = '0;
    in_query_az    = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero count after reset: always a miss, nothing read
    send_beat(mk_query(16'h8000, 16'h7fff));

    // fill the whole table, extremes in the low entries
    send_beat(mk_write(4'd0, 16'sd0, 16'sd0, 15'd64));
    send_beat(mk_write(4'd1, 16'h8000, 16'h8000, 15'h7fff));
    send_beat(mk_write(4'd2, 16'h7fff, 16'h7fff, 15'h7fff));
    send_beat(mk_write(4'd3, 16'sd100, 16'sd200, 15'd5));
    send_beat(mk_write(4'd4, 16'sd0, 16'sd0, 15'd0));
    for (int i = 5; i < MAX_SPOTS; i++)
      send_beat(mk_write(IDX_W'(i), ANGLE_BITS'($urandom()), ANGLE_BITS'($urandom()),
                         RAD_W'($urandom_range(0, 2000))));

    set_spot_count(CNT_W'(MAX_SPOTS));
    send_beat(mk_query(16'sd64, 16'sd0));      // rim of entry 0
    send_beat(mk_query(16'sd63, 16'sd0));      // just inside entry 0
    send_beat(mk_query(16'sd103, 16'sd204));   // 3-4-5 rim of entry 3
    send_beat(mk_query(16'sd102, 16'sd203));   // inside entry 3
    send_beat(mk_query(16'h8000, 16'h8000));
    send_beat(mk_query(16'h7fff, 16'h8000));   // widest distance
    send_beat(mk_query(16'sd0, 16'sd0));

    // random phases over several counts, saturation and zero among them
    phase_count[0] = 5'd1;
    phase_count[1] = 5'd31;
    phase_count[2] = 5'd16;
    phase_count[3] = CNT_W'($urandom_range(2, 15));
    phase_count[4] = 5'd0;
    phase_count[5] = CNT_W'($urandom_range(17, 30));
    phase_count[6] = 5'd16;
    phase_count[7] = CNT_W'($urandom_range(0, 31));
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_spot_count(phase_count[p]);
      idle_on = (p != 2);
      for (int n = 0; n < PHASE_BEATS; n++) send_random_beat();
    end

    drain();
    if (sb.pending_hits.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_hits.size()));
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
